// ----- hdl/tsc_pkg.sv -----
`default_nettype none
package tsc_pkg;

   // Register indexes on the configuration channel
   localparam int unsigned CSR_INDEX_WIDTH = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SWIPE_DISTANCE = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AXIS_MARGIN    = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TAP_MIN_TIME   = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TAP_MAX_MOVE   = 8'd3;

   // Register reset values
   localparam logic [15:0] SWIPE_DISTANCE_RESET = 16'd40;
   localparam logic [15:0] AXIS_MARGIN_RESET    = 16'd8;
   localparam logic [15:0] TAP_MIN_TIME_RESET   = 16'd12;
   localparam logic [15:0] TAP_MAX_MOVE_RESET   = 16'd16;

   // Gesture event codes
   typedef enum logic [1:0] {
      GESTURE_NONE  = 2'd0,
      GESTURE_TAP   = 2'd1,
      GESTURE_SWIPE = 2'd2
   } gesture_type;

   // Swipe direction codes (two-bit signed)
   localparam logic signed [1:0] DIR_ZERO = 2'sd0;
   localparam logic signed [1:0] DIR_POS  = 2'sd1;
   localparam logic signed [1:0] DIR_NEG  = -2'sd1;

   // Thresholds handed from the register block to the datapath
   typedef struct packed {
      logic [15:0] swipe_distance;
      logic [15:0] axis_margin;
      logic [15:0] tap_min_time;
      logic [15:0] tap_max_move;
   } cfg_type;

   function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
      abs_diff = (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage
`default_nettype wire

// ----- hdl/tsc_channels.sv -----
`default_nettype none

// Touch sample channel
interface tsc_req_if;
   logic        valid;
   logic        ready;
   logic        touched;
   logic [15:0] sample_x;
   logic [15:0] sample_y;
   logic [31:0] now_ms;

   modport source (output valid, touched, sample_x, sample_y, now_ms, input ready);
   modport sink   (input valid, touched, sample_x, sample_y, now_ms, output ready);
endinterface

// Classification result channel
interface tsc_rsp_if;
   logic              valid;
   logic              ready;
   logic              live;
   logic [15:0]       live_x;
   logic [15:0]       live_y;
   logic              swiping;
   logic [1:0]        gesture;
   logic [15:0]       tap_x;
   logic [15:0]       tap_y;
   logic signed [1:0] swipe_dx;
   logic signed [1:0] swipe_dy;

   modport source (output valid, live, live_x, live_y, swiping, gesture, tap_x, tap_y,
                   swipe_dx, swipe_dy, input ready);
   modport sink   (input valid, live, live_x, live_y, swiping, gesture, tap_x, tap_y,
                   swipe_dx, swipe_dy, output ready);
endinterface

// Register write channel
interface tsc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [tsc_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [15:0]                         data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/tsc_csr.sv -----
`default_nettype none
module tsc_csr
   import tsc_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   tsc_csr_if.sink   csr_chan,
   output cfg_type   cfg
);

   cfg_type cfg_ff, cfg_in;

   // Writes are always taken
   assign csr_chan.ready = 1'b1;

   // Register decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_SWIPE_DISTANCE: cfg_in.swipe_distance = csr_chan.data;
            CSR_AXIS_MARGIN:    cfg_in.axis_margin    = csr_chan.data;
            CSR_TAP_MIN_TIME:   cfg_in.tap_min_time   = csr_chan.data;
            CSR_TAP_MAX_MOVE:   cfg_in.tap_max_move   = csr_chan.data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.swipe_distance <= SWIPE_DISTANCE_RESET;
         cfg_ff.axis_margin    <= AXIS_MARGIN_RESET;
         cfg_ff.tap_min_time   <= TAP_MIN_TIME_RESET;
         cfg_ff.tap_max_move   <= TAP_MAX_MOVE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ----- hdl/touch_tap_swipe_classifier_top.sv -----
`default_nettype none
// Touch tap/swipe classifier. Every accepted touch sample yields exactly one result
// transaction: the live point, a horizontal swiping flag, and on the first untouched
// sample after a contact a one-shot gesture event (tap with its point, or swipe with
// its direction). Throughput is one sample per clock while the result side does not
// stall; a sample goes into an input register and its result leaves from the result
// register. The rate is set by the update of the contact state (start point, last point,
// down time) from the registered sample on each advance. A new sample is accepted while
// a finished result waits, if the input register is empty. The user must write registers
// over the csr channel only while no sample is in flight; the block does not enforce it.
module touch_tap_swipe_classifier_top
   import tsc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   tsc_req_if.sink    req_chan,
   tsc_rsp_if.source  rsp_chan,
   tsc_csr_if.sink    csr_chan
);

   cfg_type cfg;

   tsc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // Input register
   logic        in_valid_ff;
   logic        in_touched_ff;
   logic [15:0] in_x_ff, in_y_ff;
   logic [31:0] in_now_ff;

   // Contact state
   logic        contact_ff, contact_in;
   logic        swipe_ff, swipe_in;
   logic [15:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [15:0] last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic [31:0] down_time_ff, down_time_in;

   // Result register
   logic              out_valid_ff;
   logic              out_live_ff, out_swiping_ff;
   logic [15:0]       out_live_x_ff, out_live_y_ff, out_tap_x_ff, out_tap_y_ff;
   gesture_type       out_gesture_ff, gesture_in;
   logic signed [1:0] out_dx_ff, out_dy_ff, dx_in, dy_in;
   logic [15:0]       tap_x_in, tap_y_in;

   logic out_free, advance;

   // Handshake: input stage moves when the result register is empty or draining
   assign out_free      = !out_valid_ff || rsp_chan.ready;
   assign advance       = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_touched_ff <= req_chan.touched;
         in_x_ff       <= req_chan.sample_x;
         in_y_ff       <= req_chan.sample_y;
         in_now_ff     <= req_chan.now_ms;
      end
   end

   // Classification datapath
   logic [15:0] adx, ady, ref_x, ref_y;
   logic [16:0] ady_margin, adx_margin;
   logic [31:0] elapsed;
   logic        swipe_eff;

   always_comb begin
      contact_in   = contact_ff;
      swipe_in     = swipe_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      down_time_in = down_time_ff;
      gesture_in   = GESTURE_NONE;
      tap_x_in     = '0;
      tap_y_in     = '0;
      dx_in        = DIR_ZERO;
      dy_in        = DIR_ZERO;
      swipe_eff    = swipe_ff;

      // New contact takes the sample as its start point
      if (in_touched_ff && !contact_ff) begin
         start_x_in   = in_x_ff;
         start_y_in   = in_y_ff;
         down_time_in = in_now_ff;
         swipe_eff    = 1'b0;
      end

      // Travel: current sample while touched, last point on release
      ref_x      = in_touched_ff ? in_x_ff : last_x_ff;
      ref_y      = in_touched_ff ? in_y_ff : last_y_ff;
      adx        = abs_diff(ref_x, start_x_in);
      ady        = abs_diff(ref_y, start_y_in);
      ady_margin = {1'b0, ady} + {1'b0, cfg.axis_margin};
      adx_margin = {1'b0, adx} + {1'b0, cfg.axis_margin};
      elapsed    = in_now_ff - down_time_ff;

      if (in_touched_ff) begin
         contact_in = 1'b1;
         last_x_in  = in_x_ff;
         last_y_in  = in_y_ff;
         swipe_in   = swipe_eff || (adx >= cfg.swipe_distance && adx > ady);
      end else if (contact_ff) begin
         contact_in = 1'b0;
         swipe_in   = 1'b0;
         // Horizontal swipe wins when both axes qualify
         if (adx >= cfg.swipe_distance && {1'b0, adx} > ady_margin) begin
            gesture_in = GESTURE_SWIPE;
            dx_in      = (last_x_ff < start_x_ff) ? DIR_NEG : DIR_POS;
         end else if (ady >= cfg.swipe_distance && {1'b0, ady} > adx_margin) begin
            gesture_in = GESTURE_SWIPE;
            dy_in      = (last_y_ff < start_y_ff) ? DIR_NEG : DIR_POS;
         end else if (elapsed >= {16'd0, cfg.tap_min_time} &&
                      adx <= cfg.tap_max_move && ady <= cfg.tap_max_move) begin
            gesture_in = GESTURE_TAP;
            tap_x_in   = last_x_ff;
            tap_y_in   = last_y_ff;
         end
      end
   end

   // Contact state update, one sample per advance
   always_ff @(posedge clock) begin
      if (reset) begin
         contact_ff   <= 1'b0;
         swipe_ff     <= 1'b0;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         down_time_ff <= '0;
      end else if (advance) begin
         contact_ff   <= contact_in;
         swipe_ff     <= swipe_in;
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         down_time_ff <= down_time_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_live_ff    <= in_touched_ff;
         out_live_x_ff  <= last_x_in;
         out_live_y_ff  <= last_y_in;
         out_swiping_ff <= in_touched_ff && swipe_in;
         out_gesture_ff <= gesture_in;
         out_tap_x_ff   <= tap_x_in;
         out_tap_y_ff   <= tap_y_in;
         out_dx_ff      <= dx_in;
         out_dy_ff      <= dy_in;
      end
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.live     = out_live_ff;
   assign rsp_chan.live_x   = out_live_x_ff;
   assign rsp_chan.live_y   = out_live_y_ff;
   assign rsp_chan.swiping  = out_swiping_ff;
   assign rsp_chan.gesture  = out_gesture_ff;
   assign rsp_chan.tap_x    = out_tap_x_ff;
   assign rsp_chan.tap_y    = out_tap_y_ff;
   assign rsp_chan.swipe_dx = out_dx_ff;
   assign rsp_chan.swipe_dy = out_dy_ff;

endmodule
`default_nettype wire

// ----- hdl/tsc_checker.sv -----
`default_nettype none
module tsc_checker
   import tsc_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic              live,
   input wire logic              swiping,
   input wire logic [1:0]        gesture,
   input wire logic [15:0]       tap_x,
   input wire logic [15:0]       tap_y,
   input wire logic signed [1:0] swipe_dx,
   input wire logic signed [1:0] swipe_dy
);

   // A stalled result transaction keeps its event
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(gesture))
      else $error("stalled result changed");

   // Swiping only reported during contact, events only on release
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (swiping || gesture != GESTURE_NONE) |-> (live == swiping) &&
      !(live && gesture != GESTURE_NONE))
      else $error("swiping or gesture out of contact phase");

   // Tap point only with a tap event
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && gesture != GESTURE_TAP |-> tap_x == 16'd0 && tap_y == 16'd0)
      else $error("tap point without tap");

   // A swipe has exactly one direction, anything else has none
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (gesture == GESTURE_SWIPE) ==
      ((swipe_dx != DIR_ZERO) ^ (swipe_dy != DIR_ZERO)) &&
      !(swipe_dx != DIR_ZERO && swipe_dy != DIR_ZERO))
      else $error("swipe direction inconsistent");

endmodule

bind touch_tap_swipe_classifier_top tsc_checker u_tsc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .live      (rsp_chan.live),
   .swiping   (rsp_chan.swiping),
   .gesture   (rsp_chan.gesture),
   .tap_x     (rsp_chan.tap_x),
   .tap_y     (rsp_chan.tap_y),
   .swipe_dx  (rsp_chan.swipe_dx),
   .swipe_dy  (rsp_chan.swipe_dy)
);
`default_nettype wire

// ----- tb/touch_tap_swipe_classifier_top_tb.sv -----
`timescale 1ns / 1ps
module touch_tap_swipe_classifier_top_tb;
   import tsc_pkg::*;

   localparam int IDLE_LIMIT    = 2000;  // cycles with no transaction on any channel
   localparam int HOLD_CYCLES   = 400;   // long result-side hold-off
   localparam int DRAIN_CYCLES  = 8;
   localparam int ITEMS_PER_SET = 140;

   // One expected classification result
   typedef struct {
      logic              live;
      logic [15:0]       live_x;
      logic [15:0]       live_y;
      logic              swiping;
      gesture_type       gesture;
      logic [15:0]       tap_x;
      logic [15:0]       tap_y;
      logic signed [1:0] swipe_dx;
      logic signed [1:0] swipe_dy;
   } touch_result_type;

   logic clock = 1'b0;
   logic reset;

   tsc_req_if req_bus ();
   tsc_rsp_if rsp_bus ();
   tsc_csr_if csr_bus ();

   touch_tap_swipe_classifier_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predicted thresholds and contact state
   logic [15:0] want_swipe_distance = SWIPE_DISTANCE_RESET;
   logic [15:0] want_axis_margin    = AXIS_MARGIN_RESET;
   logic [15:0] want_tap_min_time   = TAP_MIN_TIME_RESET;
   logic [15:0] want_tap_max_move   = TAP_MAX_MOVE_RESET;
   logic        contact_down = 1'b0;
   logic        swipe_active = 1'b0;
   logic [15:0] start_x = '0;
   logic [15:0] start_y = '0;
   logic [15:0] last_x = '0;
   logic [15:0] last_y = '0;
   logic [31:0] down_time = '0;

   touch_result_type expected_results[$];

   int error_count = 0;
   int samples_sent = 0;
   int results_checked = 0;
   int taps_seen = 0;
   int swipes_seen = 0;
   int csr_writes = 0;
   int settings_applied = 0;
   int holds_done = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   bit steady_sender = 1'b0;
   bit hold_pending = 1'b0;
   logic [31:0] ms_clock = 32'd1000;

   // Classify one accepted touch sample and queue its expected result
   task automatic classify_sample(input logic touched, input logic [15:0] sx,
                                  input logic [15:0] sy, input logic [31:0] now);
      touch_result_type res;
      int unsigned   adx;
      int unsigned   ady;
      logic [31:0]   held_ms;
      res.live     = touched;
      res.swiping  = 1'b0;
      res.gesture  = GESTURE_NONE;
      res.tap_x    = '0;
      res.tap_y    = '0;
      res.swipe_dx = DIR_ZERO;
      res.swipe_dy = DIR_ZERO;
      if (touched) begin
         last_x = sx;
         last_y = sy;
         if (!contact_down) begin
            contact_down = 1'b1;
            start_x      = sx;
            start_y      = sy;
            down_time    = now;
            swipe_active = 1'b0;
         end
         adx = (sx >= start_x) ? sx - start_x : start_x - sx;
         ady = (sy >= start_y) ? sy - start_y : start_y - sy;
         if (!swipe_active && adx >= want_swipe_distance && adx > ady)
            swipe_active = 1'b1;
         res.swiping = swipe_active;
      end else if (contact_down) begin
         adx = (last_x >= start_x) ? last_x - start_x : start_x - last_x;
         ady = (last_y >= start_y) ? last_y - start_y : start_y - last_y;
         held_ms = now - down_time;
         contact_down = 1'b0;
         swipe_active = 1'b0;
         // horizontal first, then vertical, then tap
         if (adx >= want_swipe_distance && adx > ady + want_axis_margin) begin
            res.gesture  = GESTURE_SWIPE;
            res.swipe_dx = (last_x < start_x) ? DIR_NEG : DIR_POS;
         end else if (ady >= want_swipe_distance && ady > adx + want_axis_margin) begin
            res.gesture  = GESTURE_SWIPE;
            res.swipe_dy = (last_y < start_y) ? DIR_NEG : DIR_POS;
         end else if (held_ms >= want_tap_min_time && adx <= want_tap_max_move &&
                      ady <= want_tap_max_move) begin
            res.gesture = GESTURE_TAP;
            res.tap_x   = last_x;
            res.tap_y   = last_y;
         end
      end
      res.live_x = last_x;
      res.live_y = last_y;
      expected_results.push_back(res);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // Result checker: every result transaction against the oldest expectation
   always @(posedge clock) begin
      touch_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: result transaction with nothing expected", $time);
         end else begin
            want = expected_results.pop_front();
            check_field("live", 32'(want.live), 32'(rsp_bus.live));
            check_field("live_x", 32'(want.live_x), 32'(rsp_bus.live_x));
            check_field("live_y", 32'(want.live_y), 32'(rsp_bus.live_y));
            check_field("swiping", 32'(want.swiping), 32'(rsp_bus.swiping));
            check_field("gesture", 32'(want.gesture), 32'(rsp_bus.gesture));
            check_field("tap_x", 32'(want.tap_x), 32'(rsp_bus.tap_x));
            check_field("tap_y", 32'(want.tap_y), 32'(rsp_bus.tap_y));
            check_field("swipe_dx", 32'(want.swipe_dx), 32'(rsp_bus.swipe_dx));
            check_field("swipe_dy", 32'(want.swipe_dy), 32'(rsp_bus.swipe_dy));
            results_checked++;
            if (want.gesture == GESTURE_TAP) taps_seen++;
            if (want.gesture == GESTURE_SWIPE) swipes_seen++;
         end
      end
   end

   // Result-side ready: changing stall pattern, plus a long hold-off on request
   initial begin
      int mode;
      int mode_left;
      int hold_left;
      int beat;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      beat = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left = HOLD_CYCLES;
            holds_done++;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         beat++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               default: rsp_bus.ready <= (beat % 3) != 0;
            endcase
         end
      end
   end

   // Watchdog on lack of progress
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                  $time, IDLE_LIMIT, expected_results.size());
         $display("touch_tap_swipe_classifier_top_tb: done, errors");
         $finish;
      end
   end

   // Offer one sample in bursts with random gaps; predict on acceptance
   task automatic send_sample(input logic touched, input logic [15:0] sx,
                              input logic [15:0] sy, input logic [31:0] now);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = 0;
         if (!steady_sender && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_bus.valid    <= 1'b1;
      req_bus.touched  <= touched;
      req_bus.sample_x <= sx;
      req_bus.sample_y <= sy;
      req_bus.now_ms   <= now;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      classify_sample(touched, sx, sy, now);
      burst_left--;
      samples_sent++;
   endtask

   // Park the sender and let every outstanding result drain
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [7:0] index, input logic [15:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      case (index)
         CSR_SWIPE_DISTANCE: want_swipe_distance = value;
         CSR_AXIS_MARGIN:    want_axis_margin    = value;
         CSR_TAP_MIN_TIME:   want_tap_min_time   = value;
         CSR_TAP_MAX_MOVE:   want_tap_max_move   = value;
         default: ;  // unknown index leaves all thresholds alone
      endcase
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [15:0] distance, input logic [15:0] margin,
                                 input logic [15:0] min_time, input logic [15:0] max_move);
      wait_idle();
      write_register(CSR_SWIPE_DISTANCE, distance);
      write_register(CSR_AXIS_MARGIN, margin);
      write_register(CSR_TAP_MIN_TIME, min_time);
      write_register(CSR_TAP_MAX_MOVE, max_move);
      settings_applied++;
   endtask

   function automatic logic [15:0] nudge(input int v, input int span);
      int n;
      n = v + int'($urandom_range(0, 2 * span)) - span;
      if (n < 0) n = 0;
      if (n > 65535) n = 65535;
      return n[15:0];
   endfunction

   task automatic advance_ms();
      ms_clock += $urandom_range(0, 25);
      if ($urandom_range(0, 31) == 0) ms_clock = $urandom();
   endtask

   // One well-formed contact: press, a few moves, release
   task automatic send_random_contact();
      int cx;
      int cy;
      int moves;
      case ($urandom_range(0, 7))
         0: cx = 0;
         1: cx = 65535;
         default: cx = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 7))
         0: cy = 0;
         1: cy = 65535;
         default: cy = $urandom_range(0, 65535);
      endcase
      moves = $urandom_range(1, 8);
      repeat (moves) begin
         send_sample(1'b1, cx[15:0], cy[15:0], ms_clock);
         advance_ms();
         case ($urandom_range(0, 4))
            0: begin cx = nudge(cx, 3);  cy = nudge(cy, 3);  end
            1: begin cx = nudge(cx, 30); cy = nudge(cy, 30); end
            2: cx = nudge(cx, 400);
            3: cy = nudge(cy, 400);
            default: begin cx = nudge(cx, 65535); cy = nudge(cy, 65535); end
         endcase
      end
      send_sample(1'b0, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  ms_clock);
      advance_ms();
   endtask

   task automatic run_random_mix(input int count);
      int target;
      target = samples_sent + count;
      while (samples_sent < target) begin
         if ($urandom_range(0, 4) == 0)
            send_sample(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)), $urandom());
         else
            send_random_contact();
      end
   endtask

   // Directed gestures at the reset thresholds
   task automatic test_directed_gestures();
      // release with no contact in progress
      send_sample(1'b0, 16'hFFFF, 16'hFFFF, 32'd0);
      // tap held exactly the minimum time
      send_sample(1'b1, 16'd100, 16'd200, 32'd1000);
      send_sample(1'b1, 16'd105, 16'd203, 32'd1005);
      send_sample(1'b0, 16'd0, 16'd0, 32'd1012);
      // too short for a tap
      send_sample(1'b1, 16'd100, 16'd200, 32'd2000);
      send_sample(1'b0, 16'd0, 16'd0, 32'd2005);
      // swipe right, swiping flag raised at exactly the distance
      send_sample(1'b1, 16'd0, 16'd0, 32'd3000);
      send_sample(1'b1, 16'd40, 16'd10, 32'd3005);
      send_sample(1'b0, 16'd0, 16'd0, 32'd3010);
      // swipe left over the full X range
      send_sample(1'b1, 16'hFFFF, 16'd0, 32'd4000);
      send_sample(1'b1, 16'd0, 16'd0, 32'd4003);
      send_sample(1'b0, 16'd0, 16'd0, 32'd4004);
      // swipe up
      send_sample(1'b1, 16'd500, 16'd500, 32'd5000);
      send_sample(1'b1, 16'd505, 16'd400, 32'd5020);
      send_sample(1'b0, 16'd0, 16'd0, 32'd5030);
      // swipe down over the full Y range
      send_sample(1'b1, 16'd0, 16'd0, 32'd6000);
      send_sample(1'b1, 16'd0, 16'hFFFF, 32'd6001);
      send_sample(1'b0, 16'd0, 16'd0, 32'd6002);
      // tap across the timestamp wrap
      send_sample(1'b1, 16'd7, 16'd7, 32'hFFFF_FFF8);
      send_sample(1'b0, 16'd0, 16'd0, 32'h0000_0008);
      // both axes past the distance: horizontal wins
      send_sample(1'b1, 16'd1000, 16'd1000, 32'd7000);
      send_sample(1'b1, 16'd1200, 16'd1100, 32'd7010);
      send_sample(1'b0, 16'd0, 16'd0, 32'd7020);
   endtask

   // Thresholds at zero and at full scale, and ignored register indexes
   task automatic test_register_extremes();
      apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
      send_sample(1'b1, 16'd10, 16'd10, 32'd100);
      send_sample(1'b0, 16'd0, 16'd0, 32'd100);
      apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_sample(1'b1, 16'd0, 16'd0, 32'd0);
      send_sample(1'b1, 16'hFFFF, 16'd0, 32'd10);
      send_sample(1'b0, 16'd0, 16'd0, 32'd65535);
      // writes to unused indexes must not reach any threshold
      wait_idle();
      write_register(8'h04, 16'd0);
      write_register(8'hFC, 16'd0);
      write_register(8'hFF, 16'd0);
      send_sample(1'b1, 16'd100, 16'd100, 32'd200);
      send_sample(1'b1, 16'd160, 16'd100, 32'd210);
      send_sample(1'b0, 16'd0, 16'd0, 32'd220);
   endtask

   // Random contacts under several threshold settings
   task automatic test_random_settings();
      apply_settings(SWIPE_DISTANCE_RESET, AXIS_MARGIN_RESET, TAP_MIN_TIME_RESET,
                     TAP_MAX_MOVE_RESET);
      run_random_mix(ITEMS_PER_SET);
      apply_settings(16'($urandom_range(1, 120)), 16'($urandom_range(0, 40)),
                     16'($urandom_range(0, 60)), 16'($urandom_range(0, 60)));
      run_random_mix(ITEMS_PER_SET);
      apply_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      run_random_mix(ITEMS_PER_SET);
      apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
      run_random_mix(ITEMS_PER_SET);
      apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random_mix(ITEMS_PER_SET);
   endtask

   // Result side holds off while samples keep coming, so the input stalls
   task automatic test_result_backpressure();
      int target;
      apply_settings(16'($urandom_range(10, 80)), 16'($urandom_range(0, 20)),
                     16'($urandom_range(0, 30)), 16'($urandom_range(5, 40)));
      hold_pending  = 1'b1;
      steady_sender = 1'b1;
      target = samples_sent + 60;
      while (samples_sent < target) send_random_contact();
      steady_sender = 1'b0;
   endtask

   initial begin
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.touched  <= 1'b0;
      req_bus.sample_x <= '0;
      req_bus.sample_y <= '0;
      req_bus.now_ms   <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.index    <= '0;
      csr_bus.data     <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed_gestures();
      test_register_extremes();
      test_random_settings();
      test_result_backpressure();

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d touch samples and %0d results (%0d taps, %0d swipes)",
               samples_sent, results_checked, taps_seen, swipes_seen);
      $display("under %0d threshold settings, %0d register writes, %0d long hold-offs.",
               settings_applied, csr_writes, holds_done);
      if (error_count == 0)
         $display("touch_tap_swipe_classifier_top_tb: done, clean");
      else
         $display("touch_tap_swipe_classifier_top_tb: done, errors");
      $finish;
   end

endmodule
